/* src/frc_pkg.sv */
// Package for the fixed-point reciprocal block: shared types, constants, seed table.
// Used by frc_front, frc_queue, frc_back and fixed_reciprocal. No dependencies.
package frc_pkg;

    localparam int unsigned DataW      = 32;
    localparam int unsigned LzW        = 5;
    localparam int unsigned QDepthDef  = 4;

    localparam logic [DataW-1:0] SatValue  = 32'h7fff_ffff;
    localparam logic [DataW-1:0] TwoQ16    = 32'h0002_0000;
    localparam logic [DataW-1:0] TinyLimit = 32'd4;
    localparam logic [LzW-1:0]   ExpBias   = 5'd16;

    // One classified item waiting for the Newton-Raphson pipeline
    typedef struct packed {
        logic             neg;   // operand was negative
        logic             sat;   // zero or tiny magnitude: saturate
        logic [DataW-1:0] mag;   // magnitude, 2^31 for the most negative operand
        logic [DataW-1:0] seed;  // scaled initial estimate
    } t_frc_entry;

    // Seed words for 1/m, m in [1,2), picked by the three bits under the leading one
    function automatic logic [15:0] frc_seed(input logic [2:0] idx);
        logic [15:0] w;
        unique case (idx)
            3'd0:    w = 16'h8000;
            3'd1:    w = 16'h71c7;
            3'd2:    w = 16'h6666;
            3'd3:    w = 16'h5d17;
            3'd4:    w = 16'h5555;
            3'd5:    w = 16'h4ec4;
            3'd6:    w = 16'h4924;
            3'd7:    w = 16'h4444;
            default: w = 16'h8000;
        endcase
        return w;
    endfunction

endpackage

/* src/frc_front.sv */
// Front end: input register, magnitude, leading-zero count and seed selection.
// Depends on frc_pkg; pushes classified items into frc_queue.
module frc_front
    import frc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [DataW-1:0] i_operand,
    input  logic             i_full,
    output logic             o_push,
    output t_frc_entry       o_entry
);

    logic             r_vld;
    logic [DataW-1:0] r_op;

    logic             w_neg;
    logic [DataW-1:0] w_mag;
    logic [LzW-1:0]   w_lz;
    logic [DataW-1:0] w_norm;
    logic [DataW-1:0] w_base;
    logic [DataW-1:0] w_seed;

    // Input holding register; frees up as soon as the queue takes the item
    assign o_push  = r_vld && !i_full;
    assign o_ready = !r_vld || !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op <= i_operand;
        end
    end

    // Magnitude and leading-zero count (highest set bit wins)
    always_comb begin
        w_neg = r_op[DataW-1];
        w_mag = w_neg ? (32'd0 - r_op) : r_op;
        w_lz  = '0;
        for (int i = 0; i < DataW; i++) begin
            if (w_mag[i]) begin
                w_lz = LzW'(DataW - 1 - i);
            end
        end
    end

    // Seed: table word times 4, scaled by the exponent
    always_comb begin
        w_norm = w_mag << w_lz;
        w_base = {14'd0, frc_seed(w_norm[30:28]), 2'b00};
        if (w_lz <= ExpBias) begin
            w_seed = w_base >> (ExpBias - w_lz);
        end else begin
            w_seed = w_base << (w_lz - ExpBias);
        end
    end

    always_comb begin
        o_entry.neg  = w_neg;
        o_entry.sat  = (w_mag < TinyLimit);
        o_entry.mag  = w_mag;
        o_entry.seed = w_seed;
    end

endmodule

/* src/frc_queue.sv */
// Small FIFO between front and back ends so each side can stall on its own.
// Depends on frc_pkg for the entry type.
module frc_queue
    import frc_pkg::*;
#(
    parameter int unsigned Depth = QDepthDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_frc_entry i_entry,
    output logic       o_full,
    input  logic       i_pop,
    output logic       o_valid,
    output t_frc_entry o_entry
);

    localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW  = $clog2(Depth + 1);

    t_frc_entry       r_mem [Depth];
    logic [AddrW-1:0] r_wr;
    logic [AddrW-1:0] r_rd;
    logic [CntW-1:0]  r_cnt;
    logic             w_wr_en;
    logic             w_rd_en;

    assign o_full  = (r_cnt == CntW'(Depth));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];
    assign w_wr_en = i_push && !o_full;
    assign w_rd_en = i_pop && o_valid;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr_en) begin
                r_wr <= (r_wr == AddrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_rd_en) begin
                r_rd <= (r_rd == AddrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_wr_en && !w_rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_wr_en && w_rd_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // Front must never push into a full queue, back never pops an empty one
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("frc_queue: push while full");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(Depth))
        else $error("frc_queue: fill count above depth");

    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr_en && !w_rd_en) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("frc_queue: fill count missed a push");

endmodule

/* src/frc_back.sv */
// Back end: two Newton-Raphson steps x = x(2 - a x) over four multiply stages,
// then sign and saturation into the output register. Depends on frc_pkg.
module frc_back
    import frc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_frc_entry       i_q_entry,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [DataW-1:0] o_reciprocal
);

    logic [3:0]              r_vld;
    logic                    w_en;

    logic [DataW-1:0]        r_a1, r_a2;
    logic signed [DataW-1:0] r_x0, r_t1, r_x1, r_x1b, r_t2;
    logic [2:0]              r_neg, r_sat;
    logic [DataW-1:0]        r_res;

    logic signed [64:0]      w_p1, w_p3;
    logic signed [63:0]      w_p2, w_p4;
    logic signed [DataW-1:0] w_x2;
    logic [DataW-1:0]        w_res;

    // Whole pipeline advances unless the output register is full and stalled
    assign w_en    = !r_vld[3] || i_ready;
    assign o_pop   = w_en && i_q_valid;
    assign o_valid = r_vld[3];
    assign o_reciprocal = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[2:0], i_q_valid};
        end
    end

    // Products: only bits [47:16] of each are kept
    assign w_p1 = $signed({1'b0, i_q_entry.mag}) * $signed(i_q_entry.seed);
    assign w_p2 = r_x0 * r_t1;
    assign w_p3 = $signed({1'b0, r_a2}) * r_x1;
    assign w_p4 = r_x1b * r_t2;
    assign w_x2 = w_p4[47:16];

    // Sign restore; tiny magnitudes bypass it
    always_comb begin
        if (r_sat[2]) begin
            w_res = SatValue;
        end else if (r_neg[2]) begin
            w_res = 32'd0 - w_x2;
        end else begin
            w_res = w_x2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // stage 1: t1 = 2 - a*x0
            r_a1  <= i_q_entry.mag;
            r_x0  <= i_q_entry.seed;
            r_t1  <= TwoQ16 - w_p1[47:16];
            // stage 2: x1 = x0*t1
            r_a2  <= r_a1;
            r_x1  <= w_p2[47:16];
            // stage 3: t2 = 2 - a*x1
            r_x1b <= r_x1;
            r_t2  <= TwoQ16 - w_p3[47:16];
            // stage 4: x2 = x1*t2, signed result
            r_res <= w_res;
            r_neg <= {r_neg[1:0], i_q_entry.neg};
            r_sat <= {r_sat[1:0], i_q_entry.sat};
        end
    end

    // Stalled pipeline must freeze its occupancy
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("frc_back: pipeline moved during stall");

    // Every pop enters stage 1 and later shows up as a result; a pop needs a free slot and a queued item
    a_pop_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_vld[0])
        else $error("frc_back: popped item lost");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_q_valid)
        else $error("frc_back: pop without queued item");

endmodule

/* src/fixed_reciprocal.sv */
// Top level of the signed 16.16 reciprocal block.
// Depends on frc_pkg, frc_front, frc_queue and frc_back.
//
// Usage:
//   Input channel  i_valid / o_ready / i_operand   : signed 16.16 operand.
//   Output channel o_valid / i_ready / o_reciprocal: signed 16.16 reciprocal.
//   Each item is accepted when valid and ready are both high at a rising edge
//   and produces exactly one result, in order.
//   Zero and magnitudes below 4 (in LSBs) give 0x7fffffff.
// Path: after its item is accepted, a result passes the input register, the queue
//   write and then the four multiply stages before it is valid.
// Throughput: one item per cycle sustained while i_ready is high; the four
//   multiply stages each hold one multiplier (33x32 in stages one and three,
//   32x32 in stages two and four); the front end classifies one item a cycle.
// Stall: with i_ready low and a result held in the output register, the back
//   pipeline freezes; the front end keeps accepting until the queue (QDepth
//   entries) and its input register fill, then o_ready drops.
// Reset: i_rst_n is synchronous, active low; it empties the queue and all
//   pipeline stages; o_ready is high in the first cycle after reset.
module fixed_reciprocal
    import frc_pkg::*;
#(
    parameter int unsigned QDepth = QDepthDef
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [DataW-1:0] i_operand,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [DataW-1:0] o_reciprocal
);

    t_frc_entry w_push_entry;
    t_frc_entry w_pop_entry;
    logic       w_push;
    logic       w_full;
    logic       w_pop;
    logic       w_q_valid;

    frc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_operand (i_operand),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_entry   (w_push_entry)
    );

    frc_queue #(
        .Depth (QDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_entry (w_pop_entry)
    );

    frc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_entry    (w_pop_entry),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_reciprocal (o_reciprocal)
    );

endmodule

/* sim/testbench.sv */
// Self-checking testbench for fixed_reciprocal, the signed 16.16 reciprocal block.
// Depends on frc_pkg and the fixed_reciprocal RTL. A directed table comes first, then
// random operands, checked in order against typed-in answers or an in-bench reciprocal predictor.
module testbench
    import frc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumDirected = 24;
    localparam int NumRandom   = 900;
    localparam int HoldCycles  = 80;    // long receiver hold-off
    localparam int HoldAfter   = 300;   // results seen before the hold-off starts
    localparam int DrainCycles = 20;    // extra cycles after the last result
    localparam int StallLimit  = 4000;  // cycles with no transfer on either channel
    localparam int ReportMax   = 10;

    // Initial estimates of 1/m, m in [1,2), indexed by the three bits under the leading one
    localparam logic [15:0] SeedWords [8] = '{
        16'h8000, 16'h71c7, 16'h6666, 16'h5d17, 16'h5555, 16'h4ec4, 16'h4924, 16'h4444
    };

    typedef struct packed {
        logic [DataW-1:0] operand;
        logic             known;   // want holds a typed-in answer
        logic [DataW-1:0] want;
    } t_stim_row;

    typedef enum int {ShapeAny, ShapeScaled, ShapeTiny, ShapePow2, ShapeEdge, ShapeMant} t_shape;
    typedef enum int {SinkOpen, SinkCoin, SinkMask, SinkLight} t_sink_mode;

    // Directed operands: zero, tiny magnitudes, leading one at bit 2, unity, 2, 0.5, 1.75, extremes, bit patterns
    localparam t_stim_row DirectedRows [NumDirected] = '{
        '{32'h0000_0000, 1'b1, SatValue},
        '{32'h0000_0001, 1'b1, SatValue},
        '{32'h0000_0002, 1'b1, SatValue},
        '{32'h0000_0003, 1'b1, SatValue},
        '{32'hffff_ffff, 1'b1, SatValue},
        '{32'hffff_fffe, 1'b1, SatValue},
        '{32'hffff_fffd, 1'b1, SatValue},
        '{32'h0000_0004, 1'b0, 32'h0},
        '{32'h0000_0005, 1'b0, 32'h0},
        '{32'h0000_0006, 1'b0, 32'h0},
        '{32'h0000_0007, 1'b0, 32'h0},
        '{32'hffff_fffc, 1'b0, 32'h0},
        '{32'hffff_fff9, 1'b0, 32'h0},
        '{32'h0001_0000, 1'b0, 32'h0},
        '{32'hffff_0000, 1'b0, 32'h0},
        '{32'h0002_0000, 1'b0, 32'h0},
        '{32'h0000_8000, 1'b0, 32'h0},
        '{32'h0001_c000, 1'b0, 32'h0},
        '{32'h7fff_ffff, 1'b0, 32'h0},
        '{32'h8000_0001, 1'b0, 32'h0},
        '{32'h8000_0000, 1'b0, 32'h0},
        '{32'h4000_0000, 1'b0, 32'h0},
        '{32'h5555_5555, 1'b0, 32'h0},
        '{32'haaaa_aaaa, 1'b0, 32'h0}
    };

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_valid     = 1'b0;
    logic [DataW-1:0] i_operand   = '0;
    logic             i_ready     = 1'b0;
    logic             o_ready;
    logic             o_valid;
    logic [DataW-1:0] o_reciprocal;

    logic [DataW-1:0] want_now = '0;  // expected result of the item on the input port
    logic [DataW-1:0] recip_due [$];  // expected reciprocals, oldest first
    int               mismatch_count = 0;
    int               results_seen   = 0;

    fixed_reciprocal dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operand   (i_operand),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_reciprocal(o_reciprocal)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Q16.16 multiply: full signed product, arithmetic shift by 16, low 32 bits sign-extended
    function automatic longint mul_q16(input longint a, input longint b);
        longint           p;
        logic [DataW-1:0] lo;
        p  = a * b;
        p  = p >>> 16;
        lo = p[31:0];
        return {{32{lo[31]}}, lo};
    endfunction

    // Predicted reciprocal of one operand
    function automatic logic [DataW-1:0] calc_reciprocal(input logic [DataW-1:0] raw);
        logic             neg;
        logic [DataW-1:0] mag;
        logic [DataW-1:0] sh;
        logic [DataW-1:0] seed;
        logic [DataW-1:0] diff;
        logic [DataW-1:0] res;
        int               lz;
        int               shift;
        longint           x;
        longint           a;
        longint           t;
        neg = raw[31];
        mag = neg ? (32'h0 - raw) : raw;
        if (mag < TinyLimit) return SatValue;
        lz = 0;
        while (!mag[31-lz]) lz++;
        // three bits under the leading one; for the leading one at bit 2 a zero fills in
        if (lz <= 28) sh = mag >> (28 - lz);
        else          sh = mag << (lz - 28);
        seed  = {16'h0, SeedWords[sh[2:0]]} << 2;
        shift = lz - 16;
        if (shift <= 0) seed = seed >> (-shift);
        else            seed = seed << shift;
        x = {32'h0, seed};
        a = {32'h0, mag};
        // two Newton-Raphson steps x = x(2 - ax)
        repeat (2) begin
            t    = mul_q16(a, x);
            diff = TwoQ16 - t[31:0];
            x    = mul_q16(x, {{32{diff[31]}}, diff});
        end
        res = x[31:0];
        if (neg) res = 32'h0 - res;
        return res;
    endfunction

    // Random operand of a randomly picked shape
    function automatic logic [DataW-1:0] random_operand();
        t_shape           shape;
        logic [DataW-1:0] mag;
        logic [DataW-1:0] edges [6];
        edges = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'h1, 32'hffff_ffff};
        shape = t_shape'($urandom_range(0, 5));
        case (shape)
            ShapeAny:    return $urandom;
            ShapeScaled: mag = $urandom >> $urandom_range(0, 31);
            ShapeTiny:   mag = $urandom_range(0, 16);
            ShapePow2:   mag = (32'h1 << $urandom_range(0, 31)) + $urandom_range(0, 3);
            ShapeEdge:   return edges[$urandom_range(0, 5)];
            default:     mag = {28'h1, 3'($urandom_range(0, 7))} << $urandom_range(0, 27);
        endcase
        return $urandom_range(0, 1) ? (32'h0 - mag) : mag;
    endfunction

    // Present one item from the falling edge and hold it until accepted
    task automatic offer(input logic [DataW-1:0] op, input logic [DataW-1:0] want);
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_operand <= op;
        want_now  <= want;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Burst bookkeeping: at the end of a burst drop valid for a random gap, unless the gap is zero
    task automatic pace(inout int burst_left);
        int gap;
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid   <= 1'b0;
                i_operand <= $urandom;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Sender: reset, directed table, random operands, drain, verdict
    initial begin : stimulus
        int               burst_left;
        int               i;
        logic [DataW-1:0] op;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        burst_left = $urandom_range(1, 12);
        for (i = 0; i < NumDirected; i++) begin
            op = DirectedRows[i].operand;
            offer(op, DirectedRows[i].known ? DirectedRows[i].want : calc_reciprocal(op));
            pace(burst_left);
        end
        for (i = 0; i < NumRandom; i++) begin
            op = random_operand();
            offer(op, calc_reciprocal(op));
            pace(burst_left);
        end
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (recip_due.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatch_count == 0 && recip_due.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    // Receiver: ready in segments of varying patterns, one long hold-off
    initial begin : sink
        t_sink_mode mode;
        int         seg;
        int         k;
        logic [7:0] mask;
        bit         held;
        held = 1'b0;
        forever begin
            if (!held && results_seen >= HoldAfter) begin
                held = 1'b1;
                @(negedge i_clk);
                i_ready <= 1'b0;
                repeat (HoldCycles - 1) @(negedge i_clk);
                continue;
            end
            mode = t_sink_mode'($urandom_range(0, 3));
            seg  = $urandom_range(20, 200);
            mask = $urandom;
            for (k = 0; k < seg; k++) begin
                @(negedge i_clk);
                case (mode)
                    SinkOpen: i_ready <= 1'b1;
                    SinkCoin: i_ready <= 1'($urandom_range(0, 1));
                    SinkMask: i_ready <= mask[k % 8];
                    default:  i_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Scoreboard: compare each result with the oldest expectation, then log new items
    always @(posedge i_clk) begin : check
        logic [DataW-1:0] want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (recip_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= ReportMax)
                        $display("unexpected result %h, nothing pending", o_reciprocal);
                end else begin
                    want = recip_due.pop_front();
                    if (o_reciprocal !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= ReportMax)
                            $display("reciprocal mismatch: expected %h, got %h",
                                     want, o_reciprocal);
                    end
                end
            end
            if (i_valid && o_ready) recip_due.push_back(want_now);
        end
    end

    // Watchdog: end the run when nothing moves on either channel for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < StallLimit) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle = 0;
            else idle++;
        end
        $display("testbench: errors");
        $finish;
    end

endmodule

/* filelist.f */
src/frc_pkg.sv
src/frc_front.sv
src/frc_queue.sv
src/frc_back.sv
src/fixed_reciprocal.sv
sim/testbench.sv
